FILE: src/lsb_stego_payload_decoder_unit_macros.svh
// Assertion helpers shared by the decoder RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef LSB_STEGO_PAYLOAD_DECODER_UNIT_MACROS_SVH
`define LSB_STEGO_PAYLOAD_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold on every rising clock edge outside reset.
`define LSBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define LSBD_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define LSBD_ASSERT(lbl, clk, rst, prop, msg)
`define LSBD_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: src/lsbdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsbdec_pkg;

   // Field widths.
   localparam int IMAGE_BYTE_WIDTH  = 8;
   localparam int HEADER_SKIP_WIDTH = 10;
   localparam int MAGIC_WIDTH       = 16;
   localparam int LEN_WIDTH         = 32;
   localparam int KIND_WIDTH        = 2;
   localparam int INDEX_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 16;

   // Default width of the section length counter.
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Register reset values.
   localparam logic [HEADER_SKIP_WIDTH-1:0] HEADER_SKIP_RESET = 10'd54;
   localparam logic [MAGIC_WIDTH-1:0]       MAGIC_WORD_RESET  = 16'h232A;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEADER_SKIP = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAGIC_WORD  = 1'b1;

   // Result kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_EXT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PAY = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ERR = 2'd2;

   // Index of the final hidden bit of each field.
   localparam logic [INDEX_WIDTH-1:0] MAGIC_LAST_BIT = 5'd15;
   localparam logic [INDEX_WIDTH-1:0] LEN_LAST_BIT   = 5'd31;
   localparam logic [INDEX_WIDTH-1:0] BYTE_LAST_BIT  = 5'd7;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_LEN,
      PH_EXT,
      PH_PAY_LEN,
      PH_PAY,
      PH_IDLE
   } phase_type;

   // Configuration registers as seen by the parser.
   typedef struct packed {
      logic [HEADER_SKIP_WIDTH-1:0] header_skip;
      logic [MAGIC_WIDTH-1:0]       magic_word;
   } cfg_type;

   // One result produced by the parser for the current transaction.
   typedef struct packed {
      logic                        valid;
      logic [IMAGE_BYTE_WIDTH-1:0] data;
      logic [KIND_WIDTH-1:0]       kind;
      logic                        last;
   } result_type;

   // Final bit index of the field collected in the given phase.
   function automatic logic [INDEX_WIDTH-1:0] field_last_bit(input phase_type ph);
      logic [INDEX_WIDTH-1:0] idx;
      case (ph)
         PH_MAGIC:               idx = MAGIC_LAST_BIT;
         PH_EXT_LEN, PH_PAY_LEN: idx = LEN_LAST_BIT;
         default:                idx = BYTE_LAST_BIT;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: src/lsbdec_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Parse state of the hidden stream. One image byte is consumed per step and
// the result for that byte is presented combinationally.
module lsbdec_parser #(
   parameter int COUNT_WIDTH = lsbdec_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  wire                     hidden_bit,
   input  wire                     first_of_image,
   input  lsbdec_pkg::cfg_type     cfg,
   output lsbdec_pkg::result_type  result
);
   import lsbdec_pkg::*;

   // Largest section length that the counter holds; longer lengths saturate.
   localparam logic [LEN_WIDTH-1:0] COUNT_MAX =
      LEN_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

   phase_type                    phase_ff, phase_in;
   logic [HEADER_SKIP_WIDTH-1:0] header_count_ff, header_count_in;
   logic [LEN_WIDTH-1:0]         bit_shift_ff, bit_shift_in;
   logic [INDEX_WIDTH-1:0]       bit_index_ff, bit_index_in;
   logic [COUNT_WIDTH-1:0]       remaining_ff, remaining_in;

   // Next parse state and the result of the current byte.
   always_comb begin
      logic                   consumed;
      logic                   field_full;
      logic [LEN_WIDTH-1:0]   shifted;
      logic [COUNT_WIDTH-1:0] len;
      logic                   last_byte;

      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      bit_shift_in    = bit_shift_ff;
      bit_index_in    = bit_index_ff;
      remaining_in    = remaining_ff;
      result          = '0;
      consumed        = 1'b0;
      field_full      = 1'b0;
      shifted         = '0;
      len             = '0;
      last_byte       = 1'b0;

      if (step) begin
         // A new image restarts the parse at header byte zero.
         if (first_of_image) begin
            phase_in        = PH_HEADER;
            header_count_in = '0;
            bit_shift_in    = '0;
            bit_index_in    = '0;
            remaining_in    = '0;
         end

         // Header bytes are counted and dropped; the first byte past the
         // header is already the first signature bit.
         if (phase_in == PH_HEADER) begin
            if (header_count_in < cfg.header_skip) begin
               header_count_in = header_count_in + HEADER_SKIP_WIDTH'(1);
               consumed        = 1'b1;
            end else begin
               phase_in     = PH_MAGIC;
               bit_shift_in = '0;
               bit_index_in = '0;
            end
         end

         shifted    = {bit_shift_in[LEN_WIDTH-2:0], hidden_bit};
         field_full = (bit_index_in >= field_last_bit(phase_in));

         if (!consumed) begin
            case (phase_in)
               PH_MAGIC: begin
                  bit_shift_in = shifted;
                  if (field_full) begin
                     bit_index_in = '0;
                     bit_shift_in = '0;
                     if (shifted[MAGIC_WIDTH-1:0] != cfg.magic_word) begin
                        phase_in      = PH_IDLE;
                        result.valid  = 1'b1;
                        result.kind   = KIND_ERR;
                     end else begin
                        phase_in = PH_EXT_LEN;
                     end
                  end else begin
                     bit_index_in = bit_index_in + INDEX_WIDTH'(1);
                  end
               end

               PH_EXT_LEN, PH_PAY_LEN: begin
                  bit_shift_in = shifted;
                  if (field_full) begin
                     len = (shifted > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                 : shifted[COUNT_WIDTH-1:0];
                     remaining_in = len;
                     bit_index_in = '0;
                     bit_shift_in = '0;
                     if (phase_in == PH_EXT_LEN) begin
                        phase_in = (len != '0) ? PH_EXT : PH_PAY_LEN;
                     end else begin
                        phase_in = (len != '0) ? PH_PAY : PH_IDLE;
                     end
                  end else begin
                     bit_index_in = bit_index_in + INDEX_WIDTH'(1);
                  end
               end

               PH_EXT, PH_PAY: begin
                  bit_shift_in = shifted;
                  if (field_full) begin
                     last_byte     = (remaining_in <= COUNT_WIDTH'(1));
                     result.valid  = 1'b1;
                     result.data   = shifted[IMAGE_BYTE_WIDTH-1:0];
                     result.kind   = (phase_in == PH_EXT) ? KIND_EXT : KIND_PAY;
                     result.last   = last_byte;
                     bit_index_in  = '0;
                     bit_shift_in  = '0;
                     remaining_in  = last_byte ? '0 : remaining_in - COUNT_WIDTH'(1);
                     if (last_byte) begin
                        phase_in = (phase_in == PH_EXT) ? PH_PAY_LEN : PH_IDLE;
                     end
                  end else begin
                     bit_index_in = bit_index_in + INDEX_WIDTH'(1);
                  end
               end

               default: begin
                  // Idle: bytes are dropped until the next image starts.
               end
            endcase
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         bit_shift_ff    <= '0;
         bit_index_ff    <= '0;
         remaining_ff    <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_shift_ff    <= bit_shift_in;
         bit_index_ff    <= bit_index_in;
         remaining_ff    <= remaining_in;
      end
   end

`include "lsb_stego_payload_decoder_unit_macros.svh"

   `LSBD_ASSERT_NEVER(a_result_needs_step, clock, reset, result.valid && !step, "result without a consumed byte")
   `LSBD_ASSERT(a_magic_index, clock, reset, (phase_ff == PH_MAGIC) |-> (bit_index_ff <= MAGIC_LAST_BIT), "signature bit index out of range")
   `LSBD_ASSERT(a_byte_index, clock, reset, (phase_ff == PH_EXT || phase_ff == PH_PAY) |-> (bit_index_ff <= BYTE_LAST_BIT), "byte bit index out of range")
   `LSBD_ASSERT(a_section_count, clock, reset, (phase_ff == PH_EXT || phase_ff == PH_PAY) |-> (remaining_ff != '0), "data phase with nothing left to emit")

endmodule

`default_nettype wire

FILE: src/lsb_stego_payload_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// LSB steganography payload decoder. Image bytes enter on the req_ channel,
// one transaction per cycle while req_stall is low; bit 0 of each byte past
// the header is a hidden bit, MSB first. Extension characters, payload bytes
// and signature errors leave on the rsp_ channel. A byte passes an input
// register and the result register. Its result is loaded into the result
// register when the parser consumes the byte from the input register, which
// holds it while the result register is stalled. The block sustains one byte
// per cycle as long as rsp_stall stays low. The input register doubles as a
// skid stage: one more byte is taken while a result waits, and req_stall
// rises only when both stages are held. The header_skip and magic_word
// registers are written on the always-ready csr_ channel; the user must
// write them only while the decoder is idle, which the block does not enforce.
module lsb_stego_payload_decoder_unit #(
   parameter int COUNT_WIDTH = lsbdec_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                                          clock,
   input  wire                                          reset,
   // Image byte channel.
   input  wire                                          req_valid,
   output logic                                         req_stall,
   input  wire  [lsbdec_pkg::IMAGE_BYTE_WIDTH-1:0]      req_image_byte,
   input  wire                                          req_first_of_image,
   // Result channel.
   output logic                                         rsp_valid,
   input  wire                                          rsp_stall,
   output logic [lsbdec_pkg::IMAGE_BYTE_WIDTH-1:0]      rsp_out_byte,
   output logic [lsbdec_pkg::KIND_WIDTH-1:0]            rsp_out_kind,
   output logic                                         rsp_last,
   // Register write channel.
   input  wire                                          csr_valid,
   output logic                                         csr_ready,
   input  wire  [lsbdec_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire  [lsbdec_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);
   import lsbdec_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   logic                         in_bit_ff;
   logic                         in_first_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IMAGE_BYTE_WIDTH-1:0]  rsp_byte_ff;
   logic [KIND_WIDTH-1:0]        rsp_kind_ff;
   logic                         rsp_last_ff;
   logic [HEADER_SKIP_WIDTH-1:0] header_skip_ff;
   logic [MAGIC_WIDTH-1:0]       magic_word_ff;
   logic                         advance;
   logic                         step;
   logic                         req_take;
   cfg_type                      cfg;
   result_type                   result;

   // The result register can take a new value when it is empty or drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= HEADER_SKIP_RESET;
         magic_word_ff  <= MAGIC_WORD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HEADER_SKIP: header_skip_ff <= csr_wdata[HEADER_SKIP_WIDTH-1:0];
            REG_MAGIC_WORD:  magic_word_ff  <= csr_wdata[MAGIC_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.header_skip = header_skip_ff;
   assign cfg.magic_word  = magic_word_ff;

   // Input register: holds one transaction until the parser consumes it.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_bit_ff   <= req_image_byte[0];
         in_first_ff <= req_first_of_image;
      end
   end

   lsbdec_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .hidden_bit     (in_bit_ff),
      .first_of_image (in_first_ff),
      .cfg            (cfg),
      .result         (result)
   );

   // Result register.
   assign rsp_valid_in = advance ? result.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_byte_ff <= result.data;
         rsp_kind_ff <= result.kind;
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_last     = rsp_last_ff;

`include "lsb_stego_payload_decoder_unit_macros.svh"

   `LSBD_ASSERT(a_err_fields, clock, reset, (rsp_valid && rsp_out_kind == KIND_ERR) |-> (rsp_out_byte == '0 && !rsp_last), "error result carries data")
   `LSBD_ASSERT_NEVER(a_kind_code, clock, reset, rsp_valid && rsp_out_kind != KIND_EXT && rsp_out_kind != KIND_PAY && rsp_out_kind != KIND_ERR, "unknown result kind")
   `LSBD_ASSERT(a_parser_held, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_bit_ff) && $stable(in_first_ff)), "held transaction lost while result stalled")

endmodule

`default_nettype wire

FILE: tb/sv/tb_lsb_stego_payload_decoder_unit.sv
`timescale 1ns / 1ps

module tb_lsb_stego_payload_decoder_unit;
   import lsbdec_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 10;
   localparam int ITEMS_PER_MODE = 100;
   localparam int SECTION_CAP    = 8;
   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH_DEFAULT) - 64'd1;

   typedef struct packed {
      logic [IMAGE_BYTE_WIDTH-1:0] image_byte;
      logic                        first;
   } image_item_type;

   typedef struct packed {
      logic [IMAGE_BYTE_WIDTH-1:0] data;
      logic [KIND_WIDTH-1:0]       kind;
      logic                        last;
   } hidden_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [IMAGE_BYTE_WIDTH-1:0] req_image_byte = '0;
   logic                        req_first_of_image = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [IMAGE_BYTE_WIDTH-1:0] rsp_out_byte;
   logic [KIND_WIDTH-1:0]       rsp_out_kind;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata = '0;

   // Pending image bytes and the hidden results they should produce.
   image_item_type    image_queue[$];
   hidden_result_type expected_results[$];

   // Decoder state as the testbench tracks it.
   phase_type                    dec_phase;
   logic [HEADER_SKIP_WIDTH-1:0] dec_header_count;
   logic [LEN_WIDTH-1:0]         dec_shift;
   logic [INDEX_WIDTH-1:0]       dec_bit_index;
   logic [LEN_WIDTH-1:0]         dec_remaining;
   logic [HEADER_SKIP_WIDTH-1:0] cfg_header_skip;
   logic [MAGIC_WIDTH-1:0]       cfg_magic_word;

   // Register values the stimulus builds its images for.
   logic [HEADER_SKIP_WIDTH-1:0] plan_skip = HEADER_SKIP_RESET;
   logic [MAGIC_WIDTH-1:0]       plan_magic = MAGIC_WORD_RESET;
   logic                         next_first = 1'b0;
   int                           items_pushed = 0;

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;
   int idle_cycles     = 0;
   int mismatch_count  = 0;

   image_item_type next_item;

   lsb_stego_payload_decoder_unit #(
      .COUNT_WIDTH(COUNT_WIDTH_DEFAULT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_image_byte     (req_image_byte),
      .req_first_of_image (req_first_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Free-running 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Opens a new hidden field in the given phase.
   task automatic start_field(input phase_type next_phase);
      dec_phase = next_phase;
      dec_shift = '0;
      dec_bit_index = '0;
   endtask

   // Shifts one hidden bit in, MSB first. Returns 1 once the field is complete.
   function automatic logic shift_hidden_bit(input logic hidden,
                                             input logic [INDEX_WIDTH-1:0] last_index);
      logic done;
      dec_shift = {dec_shift[LEN_WIDTH-2:0], hidden};
      done = (dec_bit_index == last_index);
      dec_bit_index = done ? '0 : dec_bit_index + INDEX_WIDTH'(1);
      return done;
   endfunction

   // Advances the tracked parser by one accepted image byte.
   task automatic decode_image_byte(input logic [IMAGE_BYTE_WIDTH-1:0] raw, input logic first);
      logic                 hidden;
      logic [LEN_WIDTH-1:0] len;
      logic                 final_byte;
      hidden = raw[0];
      if (first) begin
         start_field(PH_HEADER);
         dec_header_count = '0;
         dec_remaining = '0;
      end
      if (dec_phase == PH_HEADER) begin
         if (dec_header_count < cfg_header_skip) begin
            dec_header_count = dec_header_count + HEADER_SKIP_WIDTH'(1);
            return;
         end
         start_field(PH_MAGIC);
      end
      case (dec_phase)
         PH_MAGIC: begin
            if (shift_hidden_bit(hidden, MAGIC_LAST_BIT)) begin
               if (dec_shift[MAGIC_WIDTH-1:0] != cfg_magic_word) begin
                  start_field(PH_IDLE);
                  expected_results.push_back('{data: '0, kind: KIND_ERR, last: 1'b0});
               end else begin
                  start_field(PH_EXT_LEN);
               end
            end
         end
         PH_EXT_LEN, PH_PAY_LEN: begin
            if (shift_hidden_bit(hidden, LEN_LAST_BIT)) begin
               // Lengths saturate at the width of the section counter.
               len = dec_shift;
               if ({32'd0, dec_shift} > COUNT_MAX) len = COUNT_MAX[LEN_WIDTH-1:0];
               dec_remaining = len;
               if (dec_phase == PH_EXT_LEN) start_field((len != 0) ? PH_EXT : PH_PAY_LEN);
               else start_field((len != 0) ? PH_PAY : PH_IDLE);
            end
         end
         PH_EXT, PH_PAY: begin
            if (shift_hidden_bit(hidden, BYTE_LAST_BIT)) begin
               final_byte = (dec_remaining <= 1);
               expected_results.push_back('{data: dec_shift[IMAGE_BYTE_WIDTH-1:0],
                                            kind: (dec_phase == PH_EXT) ? KIND_EXT : KIND_PAY,
                                            last: final_byte});
               dec_remaining = final_byte ? '0 : dec_remaining - LEN_WIDTH'(1);
               if (final_byte) start_field((dec_phase == PH_EXT) ? PH_PAY_LEN : PH_IDLE);
               else dec_shift = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Checks each result transaction, then tracks register writes and accepted bytes.
   always @(posedge clock) begin : scoreboard
      hidden_result_type want;
      if (reset) begin
         cfg_header_skip = HEADER_SKIP_RESET;
         cfg_magic_word = MAGIC_WORD_RESET;
         start_field(PH_HEADER);
         dec_header_count = '0;
         dec_remaining = '0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %0h kind %0d last %0d",
                                         rsp_out_byte, rsp_out_kind, rsp_last));
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %0h, expected %0h",
                                            rsp_out_byte, want.data));
               if (rsp_out_kind !== want.kind)
                  report_mismatch($sformatf("out_kind %0d, expected %0d",
                                            rsp_out_kind, want.kind));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            if (csr_index == REG_HEADER_SKIP)
               cfg_header_skip = csr_wdata[HEADER_SKIP_WIDTH-1:0];
            else if (csr_index == REG_MAGIC_WORD)
               cfg_magic_word = csr_wdata[MAGIC_WIDTH-1:0];
         end
         if (req_valid && req_stall === 1'b0)
            decode_image_byte(req_image_byte, req_first_of_image);
      end
   end

   // Image byte driver: holds a stalled transaction, otherwise offers the next one
   // or idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         req_valid <= 1'b1;
      end else if (image_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         next_item = image_queue.pop_front();
         req_valid <= 1'b1;
         req_image_byte <= next_item.image_byte;
         req_first_of_image <= next_item.first;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Ends the run when no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         report_mismatch($sformatf("no transaction for %0d cycles", WATCHDOG_LIMIT));
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_item(input logic [IMAGE_BYTE_WIDTH-1:0] raw);
      image_item_type item;
      item.image_byte = raw;
      item.first = next_first;
      image_queue.push_back(item);
      next_first = 1'b0;
      items_pushed++;
   endtask

   // Hidden bits, MSB first, each in bit 0 of an otherwise random byte.
   task automatic push_bits(input logic [LEN_WIDTH-1:0] value, input int nbits);
      logic [IMAGE_BYTE_WIDTH-2:0] pad;
      for (int i = nbits - 1; i >= 0; i--) begin
         pad = (IMAGE_BYTE_WIDTH-1)'($urandom);
         push_item({pad, value[i]});
      end
   endtask

   task automatic push_noise(input int count);
      next_first = 1'b0;
      repeat (count) push_item(IMAGE_BYTE_WIDTH'($urandom));
   endtask

   task automatic push_header(input int skip, input logic flag_first);
      next_first = flag_first;
      repeat (skip) push_item(IMAGE_BYTE_WIDTH'($urandom));
   endtask

   // A length field followed by its characters; huge lengths get a capped count.
   task automatic push_section(input logic [LEN_WIDTH-1:0] len);
      int count;
      push_bits(len, LEN_WIDTH);
      count = (len > SECTION_CAP) ? SECTION_CAP : len;
      repeat (count) push_bits($urandom, IMAGE_BYTE_WIDTH);
   endtask

   task automatic push_image(input logic flag_first, input logic [MAGIC_WIDTH-1:0] sig,
                             input logic [LEN_WIDTH-1:0] ext_len,
                             input logic [LEN_WIDTH-1:0] pay_len);
      push_header(int'(plan_skip), flag_first);
      push_bits(sig, MAGIC_WIDTH);
      push_section(ext_len);
      push_section(pay_len);
   endtask

   // Mostly well-formed images, with bad signatures, huge lengths, cut-off images,
   // unflagged images and trailing noise mixed in.
   task automatic push_random_image;
      int                      r;
      int                      base;
      int                      cut_at;
      logic [MAGIC_WIDTH-1:0]  sig;
      logic [LEN_WIDTH-1:0]    ext_len;
      logic [LEN_WIDTH-1:0]    pay_len;
      r = $urandom_range(0, 99);
      sig = plan_magic;
      if (r < 10) sig = sig ^ (16'd1 << $urandom_range(0, 15));
      ext_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      pay_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
      if (r >= 10 && r < 14) ext_len = $urandom;
      if (r >= 14 && r < 18) pay_len = $urandom;
      base = image_queue.size();
      push_image(!(r >= 34 && r < 38), sig, ext_len, pay_len);
      if (r >= 18 && r < 26) begin
         cut_at = $urandom_range(1, image_queue.size() - base);
         while (image_queue.size() > base + cut_at) void'(image_queue.pop_back());
      end
      if (r >= 26 && r < 34) push_noise($urandom_range(1, 12));
   endtask

   // Register write transaction; writes mostly come between images, one mid-header.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_HEADER_SKIP) plan_skip = value[HEADER_SKIP_WIDTH-1:0];
      else plan_magic = value[MAGIC_WIDTH-1:0];
   endtask

   task automatic write_random_config;
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) write_reg(REG_HEADER_SKIP, CSR_DATA_WIDTH'($urandom_range(0, 12)));
      else if (r < 9) write_reg(REG_HEADER_SKIP, CSR_DATA_WIDTH'($urandom_range(13, 90)));
      else write_reg(REG_HEADER_SKIP, CSR_DATA_WIDTH'(HEADER_SKIP_RESET));
      if ($urandom_range(0, 3) == 0) write_reg(REG_MAGIC_WORD, MAGIC_WORD_RESET);
      else write_reg(REG_MAGIC_WORD, CSR_DATA_WIDTH'($urandom));
   endtask

   // Waits until every byte is sent and every expected result has arrived,
   // then lets the pipeline settle.
   task automatic wait_until_drained;
      @(negedge clock);
      while (image_queue.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int mode_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      stall_pct = 68;

      // Reset values, and reset standing in for the start of the first image.
      push_image(1'b0, MAGIC_WORD_RESET, 1, 2);
      push_noise(4);
      wait_until_drained();

      // No header, both lengths zero, one section empty, and a bad signature
      // followed by ignored bytes.
      write_reg(REG_HEADER_SKIP, 16'd0);
      write_reg(REG_MAGIC_WORD, 16'hFFFF);
      push_image(1'b1, 16'hFFFF, 0, 0);
      push_noise(3);
      push_image(1'b1, 16'hFFFF, 0, 3);
      push_image(1'b1, 16'hFFFF, 2, 0);
      push_image(1'b1, 16'hFFFE, 1, 1);
      push_noise(3);
      // A huge extension length, cut short by the next image.
      push_image(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1);
      push_image(1'b1, 16'hFFFF, 1, 1);
      wait_until_drained();

      // Upper bits of a header skip write are dropped.
      write_reg(REG_HEADER_SKIP, 16'hFC03);
      write_reg(REG_MAGIC_WORD, 16'h0000);
      push_image(1'b1, 16'h0000, 1, 1);
      wait_until_drained();

      // Header skip lowered mid-header: hidden bits begin with the next byte.
      write_reg(REG_HEADER_SKIP, 16'd40);
      push_header(25, 1'b1);
      wait_until_drained();
      write_reg(REG_HEADER_SKIP, 16'd10);
      push_bits(plan_magic, MAGIC_WIDTH);
      push_section(1);
      push_section(2);

      // Random images under three idling patterns.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 34;
               stall_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               stall_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         mode_start = items_pushed;
         while (items_pushed - mode_start < ITEMS_PER_MODE) begin
            wait_until_drained();
            write_random_config();
            push_random_image();
         end
         if (mode == 1) begin
            // Sender pauses mid-image until all results are in.
            wait_until_drained();
            push_header(int'(plan_skip), 1'b1);
            push_bits(plan_magic, MAGIC_WIDTH);
            push_section(2);
            wait_until_drained();
            push_section(5);
         end
         if (mode == 2) begin
            // Receiver holds off while bytes keep coming, so the input backs up.
            wait_until_drained();
            holds_requested++;
            push_image(1'b1, plan_magic, 1, 16);
         end
      end

      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
